// ----- design/ogbd_pkg.sv -----
// ----------------------------------------------------------------------------
// ogbd_pkg
// shared types and constants of the occupancy grid block downscaler
// ----------------------------------------------------------------------------
package ogbd_pkg;

    localparam int MAX_MAP_WIDTH  = 4096;
    localparam int MAX_MAP_HEIGHT = 4096;
    localparam int MAX_SCALE      = 16;

    localparam int CELL_W   = 8;
    localparam int SCALE_W  = 5;
    localparam int THRESH_W = 9;
    localparam int DIM_W    = 13;
    localparam int POS_W    = 12;
    localparam int BLK_W    = 4;
    localparam int COUNT_W  = 9;
    localparam int ADDR_W   = $clog2(MAX_MAP_WIDTH);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 2;

    localparam logic signed [CELL_W-1:0] VAL_FREE     = 8'sd0;
    localparam logic signed [CELL_W-1:0] VAL_UNKNOWN  = -8'sd1;
    localparam logic signed [CELL_W-1:0] VAL_OCCUPIED = 8'sd100;

    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 5'd6;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd1;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd4096;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE     = 4'd0,
        REG_THRESHOLD = 4'd1,
        REG_WIDTH     = 4'd2,
        REG_HEIGHT    = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               occupied;
        logic [COUNT_W-1:0] count;
    } accum_t;

    localparam int ACCUM_W = $bits(accum_t);

    typedef struct packed {
        logic signed [CELL_W-1:0] coarse_value;
        logic                     last_of_map;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- design/occupancy_grid_block_downscale.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_block_downscale
// max-pooling downscaler for a raster stream of occupancy grid cells
// ----------------------------------------------------------------------------
// Takes one fine cell per clock, unless the input stalls, in raster order and
// emits one coarse cell when the last fine cell of each square of scale by
// scale fine cells arrives; partial squares at the right and bottom edges are
// dropped. A coarse cell is free when fewer than occupied_threshold fine cells
// are unknown or occupied, otherwise occupied if any cell was occupied, else
// unknown. The per-column accumulators live in one ram with a single read and
// a single write port: a cell is read on its transfer cycle and the updated
// accumulator is written the next cycle, with forwarding for back-to-back
// cells on the same column, so the block sustains one cell per clock when not
// stalled. A three-entry output queue absorbs output stalls; the input stalls
// only while three results are held. No clearing pass is needed after reset.
// Configuration must be written only while the block is idle; the block does
// not enforce this. A write takes effect for the next cell.
// ----------------------------------------------------------------------------
module occupancy_grid_block_downscale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ogbd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ogbd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ogbd_pkg::CELL_W-1:0]    cell_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ogbd_pkg::CELL_W-1:0]    coarse_value,
    output logic                                  last_of_map
);
    import ogbd_pkg::*;

    // configuration
    logic [SCALE_W-1:0]  scale_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [SCALE_W-1:0]  scale_eff;
    logic [DIM_W-1:0]    width_eff;
    logic [DIM_W-1:0]    height_eff;

    // raster position
    logic [POS_W-1:0]  fine_col_reg;
    logic [POS_W-1:0]  fine_col_next;
    logic [POS_W-1:0]  fine_row_reg;
    logic [POS_W-1:0]  fine_row_next;
    logic [BLK_W-1:0]  col_blk_reg;
    logic [BLK_W-1:0]  col_blk_next;
    logic [BLK_W-1:0]  row_blk_reg;
    logic [BLK_W-1:0]  row_blk_next;
    logic [ADDR_W-1:0] coarse_col_reg;
    logic [ADDR_W-1:0] coarse_col_next;

    logic accept;
    logic col_end;
    logic row_blk_end;
    logic row_end;
    logic map_end;
    logic start;
    logic emit;
    logic last;

    // update stage
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic              s1_start_reg;
    logic              s1_occ_reg;
    logic              s1_unk_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;

    // previous write, for forwarding
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_idx_reg;
    accum_t            wr_data_reg;

    logic [ACCUM_W-1:0] ram_rdata;
    accum_t             acc_old;
    accum_t             acc_new;
    result_t            result;
    logic               push;

    logic [QUEUE_CNT_W-1:0] q_count;
    logic [QUEUE_CNT_W:0]   pending;
    result_t                q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            thresh_reg <= THRESH_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:     scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                REG_WIDTH:     width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:    height_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // out-of-range settings clamp
    always_comb
    begin
        if (scale_reg == '0)
            scale_eff = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(MAX_SCALE))
            scale_eff = SCALE_W'(MAX_SCALE);
        else
            scale_eff = scale_reg;

        if (width_reg == '0)
            width_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_MAP_WIDTH))
            width_eff = DIM_W'(MAX_MAP_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_MAP_HEIGHT))
            height_eff = DIM_W'(MAX_MAP_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign pending  = {1'b0, q_count} + (QUEUE_CNT_W+1)'(s1_valid_reg && s1_emit_reg);
    assign in_stall = (pending >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    assign col_end     = ({1'b0, col_blk_reg} + 5'd1) >= scale_eff;
    assign row_blk_end = ({1'b0, row_blk_reg} + 5'd1) >= scale_eff;
    assign row_end     = ({1'b0, fine_col_reg} + 13'd1) >= width_eff;
    assign map_end     = ({1'b0, fine_row_reg} + 13'd1) >= height_eff;
    assign start       = (col_blk_reg == '0) && (row_blk_reg == '0);
    assign emit        = col_end && row_blk_end;
    assign last        = (({1'b0, fine_row_reg} + {8'd0, scale_eff}) >= height_eff)
                      && (({1'b0, fine_col_reg} + {8'd0, scale_eff}) >= width_eff);

    always_comb
    begin
        fine_col_next   = fine_col_reg;
        fine_row_next   = fine_row_reg;
        col_blk_next    = col_blk_reg;
        row_blk_next    = row_blk_reg;
        coarse_col_next = coarse_col_reg;
        if (row_end)
        begin
            fine_col_next   = '0;
            col_blk_next    = '0;
            coarse_col_next = '0;
            if (map_end)
            begin
                fine_row_next = '0;
                row_blk_next  = '0;
            end
            else
            begin
                fine_row_next = fine_row_reg + 1'b1;
                row_blk_next  = row_blk_end ? '0 : row_blk_reg + 1'b1;
            end
        end
        else
        begin
            fine_col_next = fine_col_reg + 1'b1;
            if (col_end)
            begin
                col_blk_next    = '0;
                coarse_col_next = coarse_col_reg + 1'b1;
            end
            else
            begin
                col_blk_next = col_blk_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_col_reg   <= '0;
            fine_row_reg   <= '0;
            col_blk_reg    <= '0;
            row_blk_reg    <= '0;
            coarse_col_reg <= '0;
            s1_valid_reg   <= 1'b0;
            wr_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            wr_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                fine_col_reg   <= fine_col_next;
                fine_row_reg   <= fine_row_next;
                col_blk_reg    <= col_blk_next;
                row_blk_reg    <= row_blk_next;
                coarse_col_reg <= coarse_col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= coarse_col_reg;
            s1_start_reg <= start;
            s1_occ_reg   <= (cell_value == VAL_OCCUPIED);
            s1_unk_reg   <= (cell_value == VAL_UNKNOWN);
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
        end
        if (s1_valid_reg)
        begin
            wr_idx_reg  <= s1_idx_reg;
            wr_data_reg <= acc_new;
        end
    end

    ogbd_ram #(
        .WIDTH (ACCUM_W),
        .DEPTH (MAX_MAP_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (acc_new),
        .rd_en   (accept),
        .rd_addr (coarse_col_reg),
        .rd_data (ram_rdata)
    );

    // read-modify-write with forwarding of the write that raced the read
    always_comb
    begin
        if (s1_start_reg)
            acc_old = '0;
        else if (wr_valid_reg && (wr_idx_reg == s1_idx_reg))
            acc_old = wr_data_reg;
        else
            acc_old = accum_t'(ram_rdata);

        acc_new          = acc_old;
        acc_new.count    = acc_old.count + COUNT_W'(s1_occ_reg || s1_unk_reg);
        acc_new.occupied = acc_old.occupied || s1_occ_reg;

        if (acc_new.count < thresh_reg)
            result.coarse_value = VAL_FREE;
        else if (acc_new.occupied)
            result.coarse_value = VAL_OCCUPIED;
        else
            result.coarse_value = VAL_UNKNOWN;
        result.last_of_map = s1_last_reg;
    end

    assign push = s1_valid_reg && s1_emit_reg;

    ogbd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (q_head),
        .count     (q_count)
    );

    assign coarse_value = q_head.coarse_value;
    assign last_of_map  = q_head.last_of_map;

endmodule

// ----- design/ogbd_ram.sv -----
// ----------------------------------------------------------------------------
// ogbd_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module ogbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/ogbd_out_queue.sv -----
// ----------------------------------------------------------------------------
// ogbd_out_queue
// small result queue that decouples the output stall from the pipeline
// ----------------------------------------------------------------------------
module ogbd_out_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  ogbd_pkg::result_t         push_data,
    input  logic                      out_stall,
    output logic                      out_valid,
    output ogbd_pkg::result_t         head,
    output logic [ogbd_pkg::QUEUE_CNT_W-1:0] count
);
    import ogbd_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/ogbd_checker.sv -----
// ----------------------------------------------------------------------------
// ogbd_checker
// port-level checks of the occupancy grid block downscaler
// ----------------------------------------------------------------------------
module ogbd_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [ogbd_pkg::CELL_W-1:0]    coarse_value,
    input  logic                                  last_of_map
);
    import ogbd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coarse_value) && $stable(last_of_map))
        else $error("stalled result changed");

    // only the three legal coarse codes leave the block
    a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coarse_value == VAL_FREE) || (coarse_value == VAL_UNKNOWN)
                      || (coarse_value == VAL_OCCUPIED))
        else $error("illegal coarse value");

    // input stalls only while results are held at the output
    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // a result appearing on an empty output comes from an input transfer, through the update stage and the queue
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without matching input transfer");

endmodule

bind occupancy_grid_block_downscale ogbd_checker u_ogbd_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the occupancy grid block downscaler
// ----------------------------------------------------------------------------
// Streams fine occupancy cells through the block in raster order, map by map.
// A cycle-free predictor tracks the per-column tallies and the raster position
// and queues the coarse cells each transfer should produce. Every coarse cell
// leaving the block is checked field by field against the oldest queued one.
// Registers change only while the block is drained. Directed maps cover the
// register limits, edits mid-map with one-cell squares, the zero and exact
// thresholds and the largest square; random maps follow, then a long output
// hold that backs up the input, then a steady stream with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import ogbd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 64;
    localparam int RANDOM_CELLS  = 1600;
    localparam int TOTAL_CELLS   = 1900;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [CELL_W-1:0]    cell_value;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [CELL_W-1:0]    coarse_value;
    logic                        last_of_map;

    logic [SCALE_W-1:0]          scale_reg;
    logic [THRESH_W-1:0]         thresh_reg;
    logic [DIM_W-1:0]            width_reg;
    logic [DIM_W-1:0]            height_reg;
    int unsigned                 tally_count [MAX_MAP_WIDTH];
    bit                          tally_occupied [MAX_MAP_WIDTH];
    int unsigned                 pos_col;
    int unsigned                 pos_row;
    int unsigned                 sub_col;
    int unsigned                 sub_row;
    int unsigned                 cell_col;
    result_t                     coarse_expected [$];

    int unsigned                 cells_sent;
    int unsigned                 error_count;
    int unsigned                 quiet_cycles;
    bit                          calm;
    bit                          long_hold;

    occupancy_grid_block_downscale i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_value   (cell_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coarse_value (coarse_value),
        .last_of_map  (last_of_map)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic signed [CELL_W-1:0] random_cell();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return VAL_UNKNOWN;
        if (pick < 7)
            return VAL_OCCUPIED;
        if (pick < 8)
            return VAL_FREE;
        return $signed(CELL_W'($urandom_range(0, 255)));
    endfunction

    task automatic pool_cell(input logic signed [CELL_W-1:0] v);
        int unsigned s;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        bit          col_done;
        bit          rows_done;
        result_t     r;
        s = bounded(32'(scale_reg), MAX_SCALE);
        w = bounded(32'(width_reg), MAX_MAP_WIDTH);
        h = bounded(32'(height_reg), MAX_MAP_HEIGHT);
        col = cell_col % MAX_MAP_WIDTH;
        col_done = (sub_col + 1 >= s);
        rows_done = (sub_row + 1 >= s);
        if (sub_row == 0 && sub_col == 0)
        begin
            tally_count[col] = 0;
            tally_occupied[col] = 1'b0;
        end
        if (v == VAL_OCCUPIED || v == VAL_UNKNOWN)
            tally_count[col]++;
        if (v == VAL_OCCUPIED)
            tally_occupied[col] = 1'b1;
        if (col_done && rows_done)
        begin
            if (tally_count[col] < 32'(thresh_reg))
                r.coarse_value = VAL_FREE;
            else if (tally_occupied[col])
                r.coarse_value = VAL_OCCUPIED;
            else
                r.coarse_value = VAL_UNKNOWN;
            r.last_of_map = (pos_row + s >= h) && (pos_col + s >= w);
            coarse_expected.insert(coarse_expected.size(), r);
        end
        if (pos_col + 1 >= w)
        begin
            pos_col = 0;
            sub_col = 0;
            cell_col = 0;
            if (pos_row + 1 >= h)
            begin
                pos_row = 0;
                sub_row = 0;
            end
            else
            begin
                pos_row++;
                sub_row = rows_done ? 0 : sub_row + 1;
            end
        end
        else
        begin
            pos_col++;
            if (col_done)
            begin
                sub_col = 0;
                cell_col++;
            end
            else
                sub_col++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_cell(input logic signed [CELL_W-1:0] v);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= v;
        do @(posedge clk); while (in_stall);
        pool_cell(v);
        cells_sent++;
    endtask

    task automatic send_map();
        int unsigned cells;
        cells = bounded(32'(width_reg), MAX_MAP_WIDTH)
              * bounded(32'(height_reg), MAX_MAP_HEIGHT);
        repeat (cells) send_cell(random_cell());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (coarse_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SCALE:     scale_reg  = data[SCALE_W-1:0];
            REG_THRESHOLD: thresh_reg = data[THRESH_W-1:0];
            REG_WIDTH:     width_reg  = data;
            REG_HEIGHT:    height_reg = data;
            default: ;
        endcase
    endtask

    task automatic write_unused_register();
        write_register(CFG_IDX_W'($urandom_range(int'(REG_HEIGHT) + 1, (1 << CFG_IDX_W) - 1)),
                       CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
    endtask

    task automatic configure(input int unsigned s, input int unsigned t,
                             input int unsigned w, input int unsigned h);
        write_register(REG_SCALE, CFG_DATA_W'(s));
        write_register(REG_THRESHOLD, CFG_DATA_W'(t));
        write_register(REG_WIDTH, CFG_DATA_W'(w));
        write_register(REG_HEIGHT, CFG_DATA_W'(h));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // scale zero acts as one, width past the limit, height zero
        configure(0, 1, 8191, 0);
        send_cell(VAL_UNKNOWN);
        send_cell(VAL_OCCUPIED);
        send_cell(VAL_FREE);
        send_cell(8'sh80);
        send_cell(8'sh7f);
        drain();
        // narrower width mid-row closes the row and the map
        write_register(REG_WIDTH, CFG_DATA_W'(2));
        cfg_valid <= 1'b0;
        send_cell(VAL_UNKNOWN);
        drain();
        configure(1, 1, 1, 8191);
        repeat (3) send_cell(VAL_OCCUPIED);
        drain();
        write_register(REG_HEIGHT, CFG_DATA_W'(1));
        cfg_valid <= 1'b0;
        send_cell(VAL_OCCUPIED);
        drain();
        // zero threshold on an all-free square
        configure(2, 0, 2, 2);
        send_cell(VAL_FREE);
        send_cell(8'sd5);
        send_cell(-8'sd2);
        send_cell(8'sd1);
        drain();
        write_unused_register();
        write_register(REG_THRESHOLD, CFG_DATA_W'(2));
        cfg_valid <= 1'b0;
        send_cell(VAL_OCCUPIED);
        send_cell(VAL_UNKNOWN);
        send_cell(VAL_FREE);
        send_cell(VAL_FREE);
        send_cell(VAL_UNKNOWN);
        send_cell(VAL_UNKNOWN);
        send_cell(8'sd7);
        send_cell(VAL_FREE);
        send_cell(VAL_UNKNOWN);
        send_cell(VAL_FREE);
        send_cell(VAL_FREE);
        send_cell(VAL_FREE);
    endtask

    task automatic test_largest_square();
        drain();
        configure(31, 256, 16, 16);
        repeat (256) send_cell(VAL_UNKNOWN);
        drain();
        // threshold above any reachable count
        write_register(REG_THRESHOLD, CFG_DATA_W'(511));
        cfg_valid <= 1'b0;
        send_map();
    endtask

    task automatic test_random_maps();
        int unsigned s;
        int unsigned t;
        int unsigned w;
        int unsigned h;
        int unsigned eff;
        while (cells_sent < RANDOM_CELLS)
        begin
            s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 20);
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            eff = bounded(s, MAX_SCALE);
            t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(0, eff * eff + 1);
            drain();
            if ($urandom_range(0, 3) == 0)
                write_unused_register();
            configure(s, t, w, h);
            repeat ($urandom_range(1, 3)) send_map();
        end
    endtask

    task automatic test_output_backpressure();
        drain();
        configure(1, 1, 8, 8);
        long_hold = 1'b1;
        send_map();
    endtask

    task automatic test_steady_stream();
        drain();
        calm = 1'b1;
        configure($urandom_range(2, 4), $urandom_range(0, 4), $urandom_range(8, 16),
                  $urandom_range(4, 8));
        do
            send_map();
        while (cells_sent < TOTAL_CELLS);
    endtask

    // output stall bursts, and the long hold on request
    initial
    begin
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (coarse_expected.size() == 0)
                report_mismatch($sformatf("coarse cell %0d with nothing pending", coarse_value));
            else
            begin
                want = coarse_expected.pop_front();
                if (coarse_value !== want.coarse_value)
                    report_mismatch($sformatf("coarse_value %0d, want %0d",
                                              coarse_value, want.coarse_value));
                if (last_of_map !== want.last_of_map)
                    report_mismatch($sformatf("last_of_map %0b, want %0b",
                                              last_of_map, want.last_of_map));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL occupancy_grid_block_downscale");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cell_value <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        scale_reg  = SCALE_RESET;
        thresh_reg = THRESH_RESET;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_largest_square();
        test_random_maps();
        test_output_backpressure();
        test_steady_stream();
        drain();
        if (error_count == 0)
            $display("PASS occupancy_grid_block_downscale");
        else
            $display("FAIL occupancy_grid_block_downscale");
        $finish;
    end

endmodule
